FILE: hdl/cartridge_bank_mapper_irq_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cartridge bank mapper.
// Every assertion is sampled on the rising clock edge and is disabled
// while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_UNIT_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_UNIT_ASSERT_SVH

// Plain property check.
`define CBMIRQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cbmirq assertion failed");

// Same-cycle implication.
`define CBMIRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbmirq implication failed");

// Next-cycle implication.
`define CBMIRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbmirq next-cycle implication failed");

`endif

FILE: hdl/cbmirq_pkg.sv
// ----------------------------------------------------------------------------
// cbmirq_pkg
// Types and constants shared by the bank mapper and its checker.
// ----------------------------------------------------------------------------
package cbmirq_pkg;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_TICK      = 2'd1,
    OP_CPU_XLATE = 2'd2,
    OP_PPU_XLATE = 2'd3
  } op_e;

  // CPU register addresses, exact match
  localparam logic [15:0] REG_PRG0   = 16'h8000;
  localparam logic [15:0] REG_PRG1   = 16'h8001;
  localparam logic [15:0] REG_CHR2K0 = 16'h8002;
  localparam logic [15:0] REG_CHR2K1 = 16'h8003;
  localparam logic [15:0] REG_CHR1K0 = 16'hA000;
  localparam logic [15:0] REG_CHR1K1 = 16'hA001;
  localparam logic [15:0] REG_CHR1K2 = 16'hA002;
  localparam logic [15:0] REG_CHR1K3 = 16'hA003;
  localparam logic [15:0] REG_COUNT  = 16'hC000;
  localparam logic [15:0] REG_ENABLE = 16'hC001;
  localparam logic [15:0] REG_MIRROR = 16'hE000;

  localparam int unsigned MIRROR_BIT  = 6;
  localparam logic [7:0]  COUNT_LIMIT = 8'hFF;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned MAPPED_W = 21;

endpackage

FILE: hdl/cartridge_bank_mapper_irq_unit.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq_unit
// Bank-switching cartridge mapper with a scanline interrupt counter. Each
// input word is a CPU register write, a scanline tick, or a CPU or PPU address
// to translate into a ROM byte offset; every word yields exactly one result
// word carrying the mapped offset, its valid flag, the current mirroring, the
// interrupt pulse and the counter value after the word. The unit takes one
// word per clock while the result side does not stall. An accepted word
// waits in the input register and moves into the result register once that
// register is free; the bank, mirroring and counter state are updated at
// that same edge. Stalls on the result side back up through the input
// register.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_irq_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           opcode_i,
  input  logic [cbmirq_pkg::ADDR_W-1:0]        address_i,
  input  logic [cbmirq_pkg::DATA_W-1:0]        write_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [cbmirq_pkg::MAPPED_W-1:0]      mapped_address_o,
  output logic                                 mapped_valid_o,
  output logic                                 nametable_horiz_o,
  output logic                                 irq_request_o,
  output logic [7:0]                           irq_count_now_o
);

  // input register
  logic                           in_valid_q;
  cbmirq_pkg::op_e                op_q;
  logic [cbmirq_pkg::ADDR_W-1:0]  addr_q;
  logic [cbmirq_pkg::DATA_W-1:0]  data_q;

  // mapper state
  logic [1:0][7:0] prg_q, prg_d;
  logic [1:0][7:0] chr2_q, chr2_d;
  logic [3:0][7:0] chr1_q, chr1_d;
  logic            mir_q, mir_d;
  logic            mir_auto_q, mir_auto_d;
  logic [7:0]      count_q, count_d;
  logic            en_q, en_d;

  // result register
  logic                            out_valid_q;
  logic [cbmirq_pkg::MAPPED_W-1:0] res_addr_q, res_addr_d;
  logic                            res_valid_q, res_valid_d;
  logic                            res_irq_q, res_irq_d;

  logic out_ready;
  logic step;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q   <= cbmirq_pkg::op_e'(opcode_i);
      addr_q <= address_i;
      data_q <= write_data_i;
    end
  end

  always_comb begin
    prg_d       = prg_q;
    chr2_d      = chr2_q;
    chr1_d      = chr1_q;
    mir_d       = mir_q;
    mir_auto_d  = mir_auto_q;
    count_d     = count_q;
    en_d        = en_q;
    res_addr_d  = '0;
    res_valid_d = 1'b0;
    res_irq_d   = 1'b0;
    case (op_q)
      cbmirq_pkg::OP_WRITE: begin
        case (addr_q)
          cbmirq_pkg::REG_PRG0: begin
            prg_d[0] = data_q;
            if (mir_auto_q) begin
              mir_d = data_q[cbmirq_pkg::MIRROR_BIT];
            end
          end
          cbmirq_pkg::REG_PRG1:   prg_d[1]  = data_q;
          cbmirq_pkg::REG_CHR2K0: chr2_d[0] = data_q;
          cbmirq_pkg::REG_CHR2K1: chr2_d[1] = data_q;
          cbmirq_pkg::REG_CHR1K0: chr1_d[0] = data_q;
          cbmirq_pkg::REG_CHR1K1: chr1_d[1] = data_q;
          cbmirq_pkg::REG_CHR1K2: chr1_d[2] = data_q;
          cbmirq_pkg::REG_CHR1K3: chr1_d[3] = data_q;
          cbmirq_pkg::REG_COUNT:  count_d   = data_q;
          cbmirq_pkg::REG_ENABLE: en_d      = data_q[0];
          cbmirq_pkg::REG_MIRROR: begin
            // first write here takes mirroring away from the bank register
            mir_d      = data_q[cbmirq_pkg::MIRROR_BIT];
            mir_auto_d = 1'b0;
          end
          default: ;
        endcase
      end
      cbmirq_pkg::OP_TICK: begin
        if (en_q) begin
          if (count_q == cbmirq_pkg::COUNT_LIMIT) begin
            en_d      = 1'b0;
            res_irq_d = 1'b1;
          end else begin
            count_d = count_q + 8'd1;
          end
        end
      end
      cbmirq_pkg::OP_CPU_XLATE: begin
        // 8000-BFFF: two switchable 8K windows
        if (addr_q[15:14] == 2'b10) begin
          res_addr_d  = {prg_q[addr_q[13]], addr_q[12:0]};
          res_valid_d = 1'b1;
        end
      end
      cbmirq_pkg::OP_PPU_XLATE: begin
        if (addr_q[15:13] == 3'b000) begin
          res_valid_d = 1'b1;
          if (!addr_q[12]) begin
            res_addr_d = {2'b00, chr2_q[addr_q[11]], addr_q[10:0]};
          end else begin
            res_addr_d = {3'b000, chr1_q[addr_q[11:10]], addr_q[9:0]};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_q      <= '0;
      chr2_q     <= '0;
      chr1_q     <= '0;
      mir_q      <= 1'b0;
      mir_auto_q <= 1'b1;
      count_q    <= '0;
      en_q       <= 1'b0;
    end else if (step) begin
      prg_q      <= prg_d;
      chr2_q     <= chr2_d;
      chr1_q     <= chr1_d;
      mir_q      <= mir_d;
      mir_auto_q <= mir_auto_d;
      count_q    <= count_d;
      en_q       <= en_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_addr_q  <= res_addr_d;
      res_valid_q <= res_valid_d;
      res_irq_q   <= res_irq_d;
    end
  end

  // mirroring and counter are state after the word; they move only on step
  assign out_valid_o       = out_valid_q;
  assign mapped_address_o  = res_addr_q;
  assign mapped_valid_o    = res_valid_q;
  assign nametable_horiz_o = mir_q;
  assign irq_request_o     = res_irq_q;
  assign irq_count_now_o   = count_q;

endmodule

FILE: hdl/cbmirq_checker.sv
// ----------------------------------------------------------------------------
// cbmirq_checker
// Port-level checks for the bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "cartridge_bank_mapper_irq_unit_assert.svh"

module cbmirq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [cbmirq_pkg::MAPPED_W-1:0]   mapped_address_o,
  input logic                              mapped_valid_o,
  input logic                              irq_request_o,
  input logic [7:0]                        irq_count_now_o
);

  logic                              irq_word;
  logic                              count_at_limit;
  logic                              unmapped_word;
  logic                              held_word;
  logic [cbmirq_pkg::MAPPED_W+7:0]   res_word;

  assign irq_word       = out_valid_o && irq_request_o;
  assign count_at_limit = irq_count_now_o == cbmirq_pkg::COUNT_LIMIT;
  assign unmapped_word  = out_valid_o && !mapped_valid_o;
  assign held_word      = out_valid_o && out_stall_i;
  assign res_word       = {mapped_address_o, irq_count_now_o};

  // interrupt only fires with the counter parked at its limit
  `CBMIRQ_ASSERT_IMP(a_irq_at_limit, clk_i, rst_ni, irq_word, count_at_limit)

  // unmapped results report offset zero
  `CBMIRQ_ASSERT_IMP(a_unmapped_zero, clk_i, rst_ni, unmapped_word, mapped_address_o == '0)

  // a tick never also translates
  `CBMIRQ_ASSERT(a_irq_not_mapped, clk_i, rst_ni, !(irq_word && mapped_valid_o))

  // stalled result word holds
  `CBMIRQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, held_word, out_valid_o && $stable(res_word))

endmodule

bind cartridge_bank_mapper_irq_unit cbmirq_checker u_cbmirq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .mapped_address_o (mapped_address_o),
  .mapped_valid_o   (mapped_valid_o),
  .irq_request_o    (irq_request_o),
  .irq_count_now_o  (irq_count_now_o)
);

FILE: dv/cartridge_bank_mapper_irq_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq_unit_checker
// Watches both channels of the bank mapper. Keeps its own copy of the bank
// registers, mirroring and scanline counter. Each accepted input word is
// turned into an expected result word, and each accepted result word is
// compared field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_irq_unit_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [1:0]                      opcode_i,
  input  logic [cbmirq_pkg::ADDR_W-1:0]   address_i,
  input  logic [cbmirq_pkg::DATA_W-1:0]   write_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [cbmirq_pkg::MAPPED_W-1:0] mapped_address_i,
  input  logic                            mapped_valid_i,
  input  logic                            nametable_horiz_i,
  input  logic                            irq_request_i,
  input  logic [7:0]                      irq_count_now_i,
  output int                              mismatch_count_o,
  output int                              words_pending_o,
  output int                              words_checked_o,
  output int                              irq_pulses_o
);

  typedef struct packed {
    logic [cbmirq_pkg::MAPPED_W-1:0] rom_offset;
    logic                            in_window;
    logic                            horizontal;
    logic                            irq;
    logic [7:0]                      line_count;
  } map_result_t;

  // mirror of the mapper state
  logic [7:0] prg_bank   [2];
  logic [7:0] chr2k_bank [2];
  logic [7:0] chr1k_bank [4];
  logic       mirror_h;
  logic       mirror_follows_prg;
  logic [7:0] line_count;
  logic       line_count_en;

  map_result_t expected_results [$];
  int          mismatches;
  int          checked;
  int          irq_seen;

  function automatic map_result_t map_bus_word(cbmirq_pkg::op_e op, logic [15:0] a,
                                               logic [7:0] d);
    map_result_t r;
    r = '0;
    case (op)
      cbmirq_pkg::OP_WRITE: begin
        case (a)
          cbmirq_pkg::REG_PRG0: begin
            if (mirror_follows_prg) mirror_h = d[cbmirq_pkg::MIRROR_BIT];
            prg_bank[0] = d;
          end
          cbmirq_pkg::REG_PRG1:   prg_bank[1]   = d;
          cbmirq_pkg::REG_CHR2K0: chr2k_bank[0] = d;
          cbmirq_pkg::REG_CHR2K1: chr2k_bank[1] = d;
          cbmirq_pkg::REG_CHR1K0: chr1k_bank[0] = d;
          cbmirq_pkg::REG_CHR1K1: chr1k_bank[1] = d;
          cbmirq_pkg::REG_CHR1K2: chr1k_bank[2] = d;
          cbmirq_pkg::REG_CHR1K3: chr1k_bank[3] = d;
          cbmirq_pkg::REG_COUNT:  line_count    = d;
          cbmirq_pkg::REG_ENABLE: line_count_en = d[0];
          cbmirq_pkg::REG_MIRROR: begin
            // once written here, the bank 0 write no longer touches mirroring
            mirror_h           = d[cbmirq_pkg::MIRROR_BIT];
            mirror_follows_prg = 1'b0;
          end
          default: ;
        endcase
      end
      cbmirq_pkg::OP_TICK: begin
        if (line_count_en) begin
          if (line_count == cbmirq_pkg::COUNT_LIMIT) begin
            line_count_en = 1'b0;
            r.irq         = 1'b1;
          end else begin
            line_count = line_count + 8'd1;
          end
        end
      end
      cbmirq_pkg::OP_CPU_XLATE: begin
        if (a >= 16'h8000 && a < 16'hC000) begin
          r.rom_offset = {prg_bank[a[13]], a[12:0]};
          r.in_window  = 1'b1;
        end
      end
      default: begin
        if (a < 16'h1000) begin
          r.rom_offset = cbmirq_pkg::MAPPED_W'({chr2k_bank[a[11]], a[10:0]});
          r.in_window  = 1'b1;
        end else if (a < 16'h2000) begin
          r.rom_offset = cbmirq_pkg::MAPPED_W'({chr1k_bank[a[11:10]], a[9:0]});
          r.in_window  = 1'b1;
        end
      end
    endcase
    r.horizontal = mirror_h;
    r.line_count = line_count;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    map_result_t want;
    if (!rst_ni) begin
      prg_bank           = '{default: 8'd0};
      chr2k_bank         = '{default: 8'd0};
      chr1k_bank         = '{default: 8'd0};
      mirror_h           = 1'b0;
      mirror_follows_prg = 1'b1;
      line_count         = 8'd0;
      line_count_en      = 1'b0;
      expected_results.delete();
      mismatches         = 0;
      checked            = 0;
      irq_seen           = 0;
    end else begin
      // result side first: a word accepted at this edge cannot answer itself
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (irq_request_i === 1'b1) irq_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t ns: result word with nothing expected, expected none actual %0h",
                   $time, {mapped_address_i, mapped_valid_i, nametable_horiz_i,
                           irq_request_i, irq_count_now_i});
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("mapped_address", 32'(want.rom_offset), 32'(mapped_address_i));
          check_field("mapped_valid", 32'(want.in_window), 32'(mapped_valid_i));
          check_field("nametable_horiz", 32'(want.horizontal), 32'(nametable_horiz_i));
          check_field("irq_request", 32'(want.irq), 32'(irq_request_i));
          check_field("irq_count_now", 32'(want.line_count), 32'(irq_count_now_i));
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(map_bus_word(cbmirq_pkg::op_e'(opcode_i), address_i,
                                                write_data_i));
    end
    mismatch_count_o <= mismatches;
    words_pending_o  <= expected_results.size();
    words_checked_o  <= checked;
    irq_pulses_o     <= irq_seen;
  end

endmodule

FILE: dv/cartridge_bank_mapper_irq_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq_unit_tb
// Drives register writes, scanline ticks and CPU/PPU translations into the
// bank mapper: a directed opening, then random words under four flow-control
// phases, including one long receiver hold-off. The checker does the scoring.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_irq_unit_tb;

  localparam int unsigned PHASE_WORDS = 282;

  typedef struct packed {
    cbmirq_pkg::op_e op;
    logic [15:0]     addr;
    logic [7:0]      data;
  } bus_word_t;

  logic                            clk_i        = 1'b0;
  logic                            rst_ni       = 1'b0;
  logic                            in_valid_i   = 1'b0;
  logic [1:0]                      opcode_i     = cbmirq_pkg::OP_TICK;
  logic [cbmirq_pkg::ADDR_W-1:0]   address_i    = '0;
  logic [cbmirq_pkg::DATA_W-1:0]   write_data_i = '0;
  logic                            out_stall_i  = 1'b0;
  logic                            rx_hold      = 1'b0;
  logic                            in_stall_o;
  logic                            out_valid_o;
  logic [cbmirq_pkg::MAPPED_W-1:0] mapped_address_o;
  logic                            mapped_valid_o;
  logic                            nametable_horiz_o;
  logic                            irq_request_o;
  logic [7:0]                      irq_count_now_o;

  int mismatch_count;
  int words_pending;
  int words_checked;
  int irq_pulses;
  int idle_pct  = 0;
  int stall_pct = 0;
  int words_sent = 0;

  cartridge_bank_mapper_irq_unit i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .address_i         (address_i),
    .write_data_i      (write_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .mapped_address_o  (mapped_address_o),
    .mapped_valid_o    (mapped_valid_o),
    .nametable_horiz_o (nametable_horiz_o),
    .irq_request_o     (irq_request_o),
    .irq_count_now_o   (irq_count_now_o)
  );

  cartridge_bank_mapper_irq_unit_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .opcode_i          (opcode_i),
    .address_i         (address_i),
    .write_data_i      (write_data_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .mapped_address_i  (mapped_address_o),
    .mapped_valid_i    (mapped_valid_o),
    .nametable_horiz_i (nametable_horiz_o),
    .irq_request_i     (irq_request_o),
    .irq_count_now_i   (irq_count_now_o),
    .mismatch_count_o  (mismatch_count),
    .words_pending_o   (words_pending),
    .words_checked_o   (words_checked),
    .irq_pulses_o      (irq_pulses)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= rx_hold || ($urandom_range(99) < stall_pct);
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [15:0] reg_address(int unsigned sel);
    case (sel)
      0:       return cbmirq_pkg::REG_PRG0;
      1:       return cbmirq_pkg::REG_PRG1;
      2:       return cbmirq_pkg::REG_CHR2K0;
      3:       return cbmirq_pkg::REG_CHR2K1;
      4:       return cbmirq_pkg::REG_CHR1K0;
      5:       return cbmirq_pkg::REG_CHR1K1;
      6:       return cbmirq_pkg::REG_CHR1K2;
      7:       return cbmirq_pkg::REG_CHR1K3;
      8:       return cbmirq_pkg::REG_COUNT;
      9:       return cbmirq_pkg::REG_ENABLE;
      default: return cbmirq_pkg::REG_MIRROR;
    endcase
  endfunction

  // mostly decoded registers and in-window addresses; counter loads lean
  // toward the top so the overflow pulse shows up often
  function automatic bus_word_t random_word(bit lock_ok);
    bus_word_t   w;
    int unsigned pick;
    w.addr = 16'($urandom);
    w.data = 8'($urandom);
    pick   = $urandom_range(99);
    if (pick < 35) begin
      w.op = cbmirq_pkg::OP_WRITE;
      if ($urandom_range(99) < 85) begin
        w.addr = reg_address($urandom_range(lock_ok ? 10 : 9));
        if (w.addr == cbmirq_pkg::REG_COUNT && $urandom_range(1) == 1)
          w.data = 8'($urandom_range(255, 240));
        if (w.addr == cbmirq_pkg::REG_ENABLE && $urandom_range(3) != 0)
          w.data[0] = 1'b1;
      end
    end else if (pick < 65) begin
      w.op = cbmirq_pkg::OP_TICK;
    end else if (pick < 82) begin
      w.op = cbmirq_pkg::OP_CPU_XLATE;
      if ($urandom_range(3) != 0) w.addr = 16'($urandom_range(16'hBFFF, 16'h8000));
    end else begin
      w.op = cbmirq_pkg::OP_PPU_XLATE;
      if ($urandom_range(3) != 0) w.addr = 16'($urandom_range(16'h1FFF, 0));
    end
    return w;
  endfunction

  task automatic send_word(cbmirq_pkg::op_e op, logic [15:0] addr, logic [7:0] data);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    address_i    <= addr;
    write_data_i <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  initial begin : stimulus
    bus_word_t w;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening: window edges, bank extremes, counter overflow
    send_word(cbmirq_pkg::OP_PPU_XLATE, 16'h0000, 8'h00);
    send_word(cbmirq_pkg::OP_WRITE, cbmirq_pkg::REG_PRG0, 8'hFF); // mirroring follows bit 6
    send_word(cbmirq_pkg::OP_WRITE, cbmirq_pkg::REG_PRG1, 8'h80);
    send_word(cbmirq_pkg::OP_WRITE, cbmirq_pkg::REG_CHR2K0, 8'h7F);
    send_word(cbmirq_pkg::OP_WRITE, cbmirq_pkg::REG_CHR2K1, 8'hFF);
    send_word(cbmirq_pkg::OP_WRITE, cbmirq_pkg::REG_CHR1K1, 8'hFF);
    send_word(cbmirq_pkg::OP_WRITE, cbmirq_pkg::REG_CHR1K2, 8'h55);
    send_word(cbmirq_pkg::OP_WRITE, cbmirq_pkg::REG_CHR1K3, 8'hAA);
    send_word(cbmirq_pkg::OP_WRITE, cbmirq_pkg::REG_CHR1K0, 8'h01);
    send_word(cbmirq_pkg::OP_CPU_XLATE, 16'h8000, 8'h00);
    send_word(cbmirq_pkg::OP_CPU_XLATE, 16'hBFFF, 8'hFF);
    send_word(cbmirq_pkg::OP_CPU_XLATE, 16'h7FFF, 8'h00);
    send_word(cbmirq_pkg::OP_CPU_XLATE, 16'hFFFF, 8'h00);
    send_word(cbmirq_pkg::OP_PPU_XLATE, 16'h0FFF, 8'h00);
    send_word(cbmirq_pkg::OP_PPU_XLATE, 16'h1000, 8'h00);
    send_word(cbmirq_pkg::OP_PPU_XLATE, 16'h1FFF, 8'h00);
    send_word(cbmirq_pkg::OP_PPU_XLATE, 16'hFFFF, 8'h00);
    send_word(cbmirq_pkg::OP_WRITE, 16'h8004, 8'hFF);     // not decoded
    send_word(cbmirq_pkg::OP_TICK, 16'h0000, 8'h00);      // counter disabled
    send_word(cbmirq_pkg::OP_WRITE, cbmirq_pkg::REG_COUNT, 8'hFE);
    send_word(cbmirq_pkg::OP_WRITE, cbmirq_pkg::REG_ENABLE, 8'h01);
    send_word(cbmirq_pkg::OP_TICK, 16'h0000, 8'h00);
    send_word(cbmirq_pkg::OP_TICK, 16'h0000, 8'h00);      // at limit: pulse, disable
    send_word(cbmirq_pkg::OP_TICK, 16'h0000, 8'h00);
    send_word(cbmirq_pkg::OP_WRITE, cbmirq_pkg::REG_PRG0, 8'h00);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 74; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      if (ph == 0) begin
        // long result-side hold-off while words keep coming
        fork
          begin
            repeat (20) @(posedge clk_i);
            rx_hold <= 1'b1;
            repeat (80) @(posedge clk_i);
            rx_hold <= 1'b0;
          end
        join_none
      end
      // the mirroring lock is permanent, so the first phase leaves it out of the register picks
      for (int n = 0; n < PHASE_WORDS; n++) begin
        w = random_word(ph != 0);
        send_word(w.op, w.addr, w.data);
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (words_pending != 0);
    repeat (5) @(posedge clk_i);

    $display("Sent %0d bus words over four flow-control phases with one long hold-off.",
             words_sent);
    $display("Checked %0d result words, %0d of them carrying the interrupt pulse.",
             words_checked, irq_pulses);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/cbmirq_pkg.sv
hdl/cartridge_bank_mapper_irq_unit.sv
hdl/cbmirq_checker.sv
dv/cartridge_bank_mapper_irq_unit_checker.sv
dv/cartridge_bank_mapper_irq_unit_tb.sv
